FILE: hdl/mltca_pkg.sv
// Package for the multi-lane traffic cellular automaton.
// Holds item kinds, register indexes, random generator constants and the LFSR step.
// No dependencies.
package mltca_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  localparam logic [2:0] REG_MAX_VELOCITY = 3'd0;
  localparam logic [2:0] REG_GAP_MARGIN   = 3'd1;
  localparam logic [2:0] REG_INJECT       = 3'd2;
  localparam logic [2:0] REG_SLOWDOWN     = 3'd3;
  localparam logic [2:0] REG_LANE_CHANGE  = 3'd4;
  localparam logic [2:0] REG_SEED         = 3'd5;

  localparam logic [15:0] LFSR_TAPS    = 16'hB400;
  localparam logic [15:0] SEED_DEFAULT = 16'd44257;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // One step of the right-shifting Galois LFSR; the result is the draw.
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

FILE: hdl/multilane_traffic_ca_step.sv
// Top level of the multi-lane traffic cellular automaton.
// Uses mltca_pkg; the road lives in two banks of synchronous memory.
// A write or unused item goes straight to the output state; a read item first reads memory.
// Step item: a clear of the next bank, an injection read and write, a scan through the
// current bank of LANE_COUNT*(ROAD_CELLS+1) positions at one cell a cycle, a drain, a
// finish and an output. One item at a time.
// Reset: synchronous; a clearing pass over all LANE_COUNT*ROAD_CELLS cells empties both
// banks, during which no item is accepted (configuration writes are taken).
module multilane_traffic_ca_step #(
  parameter int ROAD_CELLS = 256,
  parameter int LANE_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] lane_index, [9:2] cell_position, [10] write_occupied, [14:11] write_velocity
  input  logic [mltca_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] cell_occupied, [4:1] cell_velocity, [36:5] step_count
  output logic [mltca_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int GRID = LANE_COUNT * ROAD_CELLS;
  localparam int AW   = $clog2(GRID);
  localparam int PW1  = $clog2(ROAD_CELLS + 1);
  localparam int PW   = $clog2(ROAD_CELLS + 16);
  localparam int LW   = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;

  typedef enum logic [8:0] {
    ST_INIT  = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_RD    = 9'b000000100,
    ST_OUT   = 9'b000001000,
    ST_CLEAR = 9'b000010000,
    ST_INJR  = 9'b000100000,
    ST_INJW  = 9'b001000000,
    ST_SCAN  = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration.
  logic [3:0]  vmax_r, gm_r;
  logic [15:0] inj_r, sd_r, lc_r, seed_r;
  logic [15:0] lfsr_r;
  logic [31:0] tc_r;
  logic        cur_sel_r;

  // Memories.
  logic [4:0] mem0 [GRID];
  logic [4:0] mem1 [GRID];
  logic [4:0] rd0a_r, rd0b_r, rd1a_r, rd1b_r;
  logic       rsela_r;
  logic       rsela;
  logic [AW-1:0] raddra, raddrb, waddr;
  logic [4:0]    wdata;
  logic          we0, we1;
  logic [4:0]    rda, rdb;

  // Sequencing.
  logic [AW-1:0] clr_cnt_r;
  logic [5:0]    mod_cnt_r;
  logic [31:0]   mod_sh_r;
  logic [15:0]   mod_rem_r;
  logic [LW-1:0] rl_r;
  logic [LW-1:0] sc_lane_r;
  logic [PW1-1:0] sc_pos_r;
  logic          sc_run_r;
  logic          s1_valid_r, s1_end_r;
  logic [LW-1:0] s1_lane_r;
  logic [PW1-1:0] s1_pos_r;
  logic          pend_valid_r;
  logic [LW-1:0] pend_lane_r;
  logic [PW1-1:0] pend_pos_r;
  logic [3:0]    pend_vel_r;
  logic          f2_valid_r, f2_try_r;
  logic [LW-1:0] f2_lane_r, f2_nl_r;
  logic [PW1-1:0] f2_pos_r;
  logic [3:0]    f2_v_r;

  // Result.
  logic       res_occ_r;
  logic [3:0] res_vel_r;
  logic       res_inside_r;
  logic       out_valid_r;
  logic [mltca_pkg::OUT_DATA_W-1:0] out_data_r;

  // Input fields.
  logic [1:0] in_kind, in_lane;
  logic [7:0] in_pos;
  logic       in_wocc;
  logic [3:0] in_wvel;
  assign in_kind = in_tuser;
  assign in_lane = in_tdata[1:0];
  assign in_pos  = in_tdata[9:2];
  assign in_wocc = in_tdata[10];
  assign in_wvel = in_tdata[14:11];

  logic in_acc, cfg_wr, live_sel, in_inside;
  logic [AW-1:0] in_addr;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite;
  assign live_sel  = (tc_r == 32'd1) ? cur_sel_r : ~cur_sel_r;
  assign in_inside = ({30'd0, in_lane} < 32'(LANE_COUNT)) && ({24'd0, in_pos} < 32'(ROAD_CELLS));
  assign in_addr   = AW'(AW'(in_lane) * AW'(ROAD_CELLS) + AW'(in_pos));

  always_comb begin
    cfg_prdata = 32'd0;
    case (cfg_paddr[4:2])
      mltca_pkg::REG_MAX_VELOCITY: cfg_prdata = {28'd0, vmax_r};
      mltca_pkg::REG_GAP_MARGIN:   cfg_prdata = {28'd0, gm_r};
      mltca_pkg::REG_INJECT:       cfg_prdata = {16'd0, inj_r};
      mltca_pkg::REG_SLOWDOWN:     cfg_prdata = {16'd0, sd_r};
      mltca_pkg::REG_LANE_CHANGE:  cfg_prdata = {16'd0, lc_r};
      mltca_pkg::REG_SEED:         cfg_prdata = {16'd0, seed_r};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

  assign rda = rsela_r ? rd1a_r : rd0a_r;
  assign rdb = cur_sel_r ? rd1b_r : rd0b_r;

  // Random lane for injection.
  logic [15:0] inj_draw;
  logic [20:0] inj_prod;
  logic [4:0]  inj_lane;
  assign inj_draw = mltca_pkg::lfsr_step(lfsr_r);
  assign inj_prod = {5'd0, inj_draw} * 21'(LANE_COUNT);
  always_comb begin
    inj_lane = inj_prod[20:16];
    if ({27'd0, inj_lane} >= 32'(LANE_COUNT)) begin
      inj_lane = 5'(LANE_COUNT - 1);
    end
  end

  // Remainder step of time counter by inject period.
  logic [16:0] mod_t;
  always_comb begin
    mod_t = {mod_rem_r, mod_sh_r[31]};
    if (mod_t >= {1'b0, inj_r}) begin
      mod_t = mod_t - {1'b0, inj_r};
    end
  end

  // Scan stage one: a car or the lane end finalizes the pending car.
  logic s1_event, fin;
  assign s1_event = s1_valid_r && (s1_end_r || rda[4]);
  assign fin      = s1_event && pend_valid_r;

  logic [4:0]     f1_v1;
  logic [PW1-1:0] f1_gap, f1_lim;
  logic [3:0]     f1_v;
  logic [15:0]    f1_d1, f1_l1, f1_d2, f1_l2;
  logic           f1_want, f1_dn, f1_ok;
  logic [LW-1:0]  f1_nl;
  always_comb begin
    f1_v1 = {1'b0, pend_vel_r} + 5'd1;
    if (f1_v1 > {1'b0, vmax_r}) begin
      f1_v1 = {1'b0, vmax_r};
    end
    f1_gap = s1_pos_r - pend_pos_r;
    f1_lim = (f1_gap > PW1'(gm_r)) ? (f1_gap - PW1'(gm_r)) : '0;
    f1_v = f1_v1[3:0];
    if (!s1_end_r && (PW1'(f1_v1[3:0]) > f1_lim)) begin
      f1_v = f1_lim[3:0];
    end
    f1_d1 = mltca_pkg::lfsr_step(lfsr_r);
    f1_l1 = (sd_r != 16'd0) ? f1_d1 : lfsr_r;
    if ((sd_r != 16'd0) && (f1_d1 > sd_r) && (f1_v != 4'd0)) begin
      f1_v = f1_v - 4'd1;
    end
    f1_d2 = mltca_pkg::lfsr_step(f1_l1);
    f1_l2 = (lc_r != 16'd0) ? f1_d2 : f1_l1;
    f1_want = (lc_r != 16'd0) && (f1_d2 > lc_r);
    f1_dn = ~tc_r[0];
    f1_ok = f1_dn ? (pend_lane_r != '0) : (pend_lane_r != LW'(LANE_COUNT - 1));
    f1_nl = f1_dn ? (pend_lane_r - LW'(1)) : (pend_lane_r + LW'(1));
  end

  // Stage two: final placement in the next bank.
  logic [PW-1:0] f2_np;
  assign f2_np = PW'(f2_pos_r) + PW'(f2_v_r);

  always_comb begin
    raddrb = AW'(AW'(f1_nl) * AW'(ROAD_CELLS) + AW'(pend_pos_r));
    raddra = AW'(AW'(sc_lane_r) * AW'(ROAD_CELLS) + AW'(sc_pos_r));
    rsela  = cur_sel_r;
    we0 = 1'b0;
    we1 = 1'b0;
    waddr = clr_cnt_r;
    wdata = 5'd0;
    case (state_r)
      ST_INIT: begin
        we0 = 1'b1;
        we1 = 1'b1;
      end
      ST_IDLE: begin
        raddra = in_addr;
        rsela  = live_sel;
        waddr  = in_addr;
        wdata  = {in_wocc, in_wvel};
        if (in_acc && (in_kind == mltca_pkg::KIND_WRITE) && in_inside) begin
          we0 = ~live_sel;
          we1 = live_sel;
        end
      end
      ST_CLEAR: begin
        we0 = cur_sel_r;
        we1 = ~cur_sel_r;
      end
      ST_INJR: begin
        raddra = AW'(AW'(rl_r) * AW'(ROAD_CELLS));
      end
      ST_INJW: begin
        waddr = AW'(AW'(rl_r) * AW'(ROAD_CELLS));
        wdata = 5'b10001;
        if ((inj_r != 16'd0) && (mod_rem_r == 16'd0) && !rda[4]) begin
          we0 = ~cur_sel_r;
          we1 = cur_sel_r;
        end
      end
      ST_SCAN: begin
        if (f2_valid_r) begin
          we0 = cur_sel_r;
          we1 = ~cur_sel_r;
          if (f2_try_r && !rdb[4]) begin
            waddr = AW'(AW'(f2_nl_r) * AW'(ROAD_CELLS) + AW'(f2_pos_r));
            wdata = {1'b1, f2_v_r};
          end else if (f2_np >= PW'(ROAD_CELLS)) begin
            waddr = AW'(AW'(f2_lane_r) * AW'(ROAD_CELLS) + AW'(f2_pos_r));
            wdata = 5'd0;
          end else begin
            waddr = AW'(AW'(f2_lane_r) * AW'(ROAD_CELLS) + AW'(f2_np));
            wdata = {1'b1, f2_v_r};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    rd0a_r <= mem0[raddra];
    rd0b_r <= mem0[raddrb];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    rd1a_r <= mem1[raddra];
    rd1b_r <= mem1[raddrb];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:  if (clr_cnt_r == AW'(GRID - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == mltca_pkg::KIND_READ) begin
            state_nxt = ST_RD;
          end else if (in_kind == mltca_pkg::KIND_STEP) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_RD:    state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      ST_CLEAR: begin
        if ((clr_cnt_r == AW'(GRID - 1)) && (mod_cnt_r == 6'd0)) state_nxt = ST_INJR;
      end
      ST_INJR:  state_nxt = ST_INJW;
      ST_INJW:  state_nxt = ST_SCAN;
      ST_SCAN:  if (!sc_run_r && !s1_valid_r && !f2_valid_r) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_OUT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      vmax_r       <= 4'd5;
      gm_r         <= 4'd1;
      inj_r        <= 16'd0;
      sd_r         <= 16'd0;
      lc_r         <= 16'd0;
      seed_r       <= mltca_pkg::SEED_DEFAULT;
      lfsr_r       <= mltca_pkg::SEED_DEFAULT;
      tc_r         <= 32'd1;
      cur_sel_r    <= 1'b0;
      clr_cnt_r    <= '0;
      mod_cnt_r    <= 6'd0;
      sc_run_r     <= 1'b0;
      s1_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      f2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          mltca_pkg::REG_MAX_VELOCITY: vmax_r <= cfg_pwdata[3:0];
          mltca_pkg::REG_GAP_MARGIN:   gm_r   <= cfg_pwdata[3:0];
          mltca_pkg::REG_INJECT:       inj_r  <= cfg_pwdata[15:0];
          mltca_pkg::REG_SLOWDOWN:     sd_r   <= cfg_pwdata[15:0];
          mltca_pkg::REG_LANE_CHANGE:  lc_r   <= cfg_pwdata[15:0];
          mltca_pkg::REG_SEED: begin
            seed_r <= cfg_pwdata[15:0];
            lfsr_r <= (cfg_pwdata[15:0] != 16'd0) ? cfg_pwdata[15:0] : mltca_pkg::SEED_DEFAULT;
          end
          default: begin
          end
        endcase
      end
      if ((state_r == ST_INIT) || (state_r == ST_CLEAR)) begin
        if (clr_cnt_r != AW'(GRID - 1)) clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (mod_cnt_r != 6'd0) begin
        mod_cnt_r <= mod_cnt_r - 6'd1;
      end
      if (in_acc && (in_kind == mltca_pkg::KIND_STEP)) begin
        if (tc_r != 32'd1) cur_sel_r <= ~cur_sel_r;
        lfsr_r    <= inj_draw;
        clr_cnt_r <= '0;
        mod_cnt_r <= 6'd32;
      end
      if (state_r == ST_INJW) begin
        sc_run_r     <= 1'b1;
        pend_valid_r <= 1'b0;
      end
      if ((state_r == ST_SCAN) && sc_run_r) begin
        if (sc_pos_r == PW1'(ROAD_CELLS)) begin
          if (sc_lane_r == LW'(LANE_COUNT - 1)) sc_run_r <= 1'b0;
        end
      end
      s1_valid_r <= (state_r == ST_SCAN) && sc_run_r;
      f2_valid_r <= fin;
      if (s1_event) begin
        pend_valid_r <= rda[4] && !s1_end_r;
      end
      if (fin) begin
        lfsr_r <= f1_l2;
      end
      if (state_r == ST_FIN) begin
        tc_r <= tc_r + 32'd1;
      end
      if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc && (in_kind == mltca_pkg::KIND_STEP)) begin
      rl_r     <= LW'(inj_lane);
      mod_sh_r <= tc_r;
      mod_rem_r <= 16'd0;
    end else if (mod_cnt_r != 6'd0) begin
      mod_sh_r  <= {mod_sh_r[30:0], 1'b0};
      mod_rem_r <= mod_t[15:0];
    end
    if (state_r == ST_INJW) begin
      sc_lane_r <= '0;
      sc_pos_r  <= '0;
    end else if ((state_r == ST_SCAN) && sc_run_r) begin
      if (sc_pos_r == PW1'(ROAD_CELLS)) begin
        sc_pos_r <= '0;
        if (sc_lane_r != LW'(LANE_COUNT - 1)) sc_lane_r <= sc_lane_r + LW'(1);
      end else begin
        sc_pos_r <= sc_pos_r + PW1'(1);
      end
    end
    rsela_r   <= rsela;
    s1_lane_r <= sc_lane_r;
    s1_pos_r  <= sc_pos_r;
    s1_end_r  <= (sc_pos_r == PW1'(ROAD_CELLS));
    if (s1_event) begin
      pend_lane_r <= s1_lane_r;
      pend_pos_r  <= s1_pos_r;
      pend_vel_r  <= rda[3:0];
    end
    f2_try_r  <= f1_want && f1_ok;
    f2_lane_r <= pend_lane_r;
    f2_nl_r   <= f1_nl;
    f2_pos_r  <= pend_pos_r;
    f2_v_r    <= f1_v;
    if (in_acc) begin
      res_occ_r    <= 1'b0;
      res_vel_r    <= 4'd0;
      res_inside_r <= in_inside;
    end else if (state_r == ST_RD) begin
      res_occ_r <= res_inside_r && rda[4];
      res_vel_r <= res_inside_r ? rda[3:0] : 4'd0;
    end else if (state_r == ST_FIN) begin
      res_occ_r <= 1'b0;
      res_vel_r <= 4'd0;
    end
    if ((state_r == ST_OUT) && (!out_valid_r || out_tready)) begin
      out_data_r <= {3'd0, tc_r, res_vel_r, res_occ_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: hdl/mltca_checker.sv
// Port-level checker for the traffic automaton top level, with its bind statement.
// Uses mltca_pkg for item kinds and the output width; sees only the ports of the top level.
module mltca_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [mltca_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic        cfg_pready
);

  // A waiting result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A step item keeps the input side closed on the next cycle.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == mltca_pkg::KIND_STEP) |=> !in_tready)
    else $error("input open right after a step item");

  // A read item needs a memory read before the next item is taken.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == mltca_pkg::KIND_READ) |=> !in_tready)
    else $error("input open right after a read item");

  // Reset leaves no result on the output and the input side closed.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_tready)
    else $error("channel active after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port stalled");

endmodule

bind multilane_traffic_ca_step mltca_checker u_mltca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

FILE: bench/multilane_traffic_ca_step_tb.sv
// Self-checking testbench for the multi-lane traffic cellular automaton.
// Uses mltca_pkg and multilane_traffic_ca_step; a table or a road predictor sets each result.
module multilane_traffic_ca_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROADS = 256;
  localparam int LANES = 4;
  localparam logic [1:0] K_WRITE  = mltca_pkg::KIND_WRITE;
  localparam logic [1:0] K_READ   = mltca_pkg::KIND_READ;
  localparam logic [1:0] K_STEP   = mltca_pkg::KIND_STEP;
  localparam logic [1:0] K_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        occ;
    logic [3:0]  vel;
    logic [31:0] step;
  } cell_res_t;

  typedef struct {
    logic [1:0] kind;
    logic [1:0] lane;
    logic [7:0] pos;
    logic       wocc;
    logic [3:0] wvel;
    bit         typed;
    cell_res_t  res;
  } road_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [mltca_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [mltca_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Predictor state.
  logic [4:0]  road_cur [LANES*ROADS];
  logic [4:0]  road_nxt [LANES*ROADS];
  logic [31:0] tick;
  logic [15:0] lfsr;
  logic [3:0]  vmax, margin;
  logic [15:0] inj_period, slow_thr, lane_thr;

  cell_res_t expected_cells [$];
  int  errors = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_cnt = 0;
  int  rx_burst = 0;
  int  idle_cycles = 0;

  always #5 clk = ~clk;

  multilane_traffic_ca_step u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  function automatic logic [15:0] next_draw();
    lfsr = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? mltca_pkg::LFSR_TAPS : 16'h0000);
    return lfsr;
  endfunction

  task automatic advance_road();
    int lane, pos, i, v, lim, np, nl, base, rl;
    bit moved, down, ok;
    logic [15:0] d;
    if (tick != 32'd1) road_cur = road_nxt;
    d = next_draw();
    rl = int'(d[15:14]);
    if (inj_period != 0 && !road_cur[rl*ROADS][4] && (tick % {16'h0, inj_period}) == 0)
      road_cur[rl*ROADS] = 5'h11;
    foreach (road_nxt[k]) road_nxt[k] = 5'h00;
    for (lane = 0; lane < LANES; lane++) begin
      base = lane * ROADS;
      for (pos = 0; pos < ROADS; pos++) begin
        if (road_cur[base+pos][4]) begin
          moved = 1'b0;
          v = int'(road_cur[base+pos][3:0]) + 1;
          if (v > int'(vmax)) v = int'(vmax);
          for (i = pos + 1; i < ROADS; i++) begin
            if (road_cur[base+i][4]) begin
              lim = (i - pos > int'(margin)) ? i - pos - int'(margin) : 0;
              if (v > lim) v = lim;
              break;
            end
          end
          if (slow_thr != 0 && next_draw() > slow_thr) v = (v > 0) ? v - 1 : 0;
          if (lane_thr != 0 && next_draw() > lane_thr) begin
            down = (tick[0] == 1'b0);
            ok = down ? (lane > 0) : (lane + 1 < LANES);
            if (ok) begin
              nl = down ? lane - 1 : lane + 1;
              if (!road_cur[nl*ROADS+pos][4]) begin
                road_nxt[nl*ROADS+pos] = {1'b1, v[3:0]};
                moved = 1'b1;
              end
            end
          end
          if (!moved) begin
            np = pos + v;
            if (np >= ROADS) road_nxt[base+pos] = 5'h00;
            else road_nxt[base+np] = {1'b1, v[3:0]};
          end
        end
      end
    end
    tick = tick + 32'd1;
  endtask

  task automatic predict_cell(input logic [1:0] kind, input logic [1:0] lane,
                              input logic [7:0] pos, input logic wocc, input logic [3:0] wvel,
                              output cell_res_t res);
    int idx;
    idx = int'(lane) * ROADS + int'(pos);
    res = '0;
    case (kind)
      K_WRITE: begin
        if (tick == 32'd1) road_cur[idx] = {wocc, wvel};
        else road_nxt[idx] = {wocc, wvel};
      end
      K_READ: begin
        {res.occ, res.vel} = (tick == 32'd1) ? road_cur[idx] : road_nxt[idx];
      end
      K_STEP: advance_road();
      default: ;
    endcase
    res.step = tick;
  endtask

  // Offers one item, waits for the handshake, then records what it should produce.
  task automatic send_item(input road_row_t row);
    int gap;
    cell_res_t res;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 18)) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.kind;
    in_tdata  <= {1'b0, row.wvel, row.wocc, row.pos, row.lane};
    do @(posedge clk); while (!in_tready);
    predict_cell(row.kind, row.lane, row.pos, row.wocc, row.wvel, res);
    expected_cells.push_back(row.typed ? row.res : res);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    in_tvalid <= 1'b0;
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      mltca_pkg::REG_MAX_VELOCITY: vmax = val[3:0];
      mltca_pkg::REG_GAP_MARGIN:   margin = val[3:0];
      mltca_pkg::REG_INJECT:       inj_period = val[15:0];
      mltca_pkg::REG_SLOWDOWN:     slow_thr = val[15:0];
      mltca_pkg::REG_LANE_CHANGE:  lane_thr = val[15:0];
      mltca_pkg::REG_SEED:
        lfsr = (val[15:0] != 16'd0) ? val[15:0] : mltca_pkg::SEED_DEFAULT;
      default: ;
    endcase
  endtask

  task automatic set_road_rules(input logic [3:0] mv, input logic [3:0] gm,
                                input logic [15:0] ip, input logic [15:0] st,
                                input logic [15:0] lt, input logic [15:0] sd);
    // Drop the last item at once so that it is not taken a second time.
    in_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(mltca_pkg::REG_MAX_VELOCITY, {28'd0, mv});
    write_reg(mltca_pkg::REG_GAP_MARGIN, {28'd0, gm});
    write_reg(mltca_pkg::REG_INJECT, {16'd0, ip});
    write_reg(mltca_pkg::REG_SLOWDOWN, {16'd0, st});
    write_reg(mltca_pkg::REG_LANE_CHANGE, {16'd0, lt});
    write_reg(mltca_pkg::REG_SEED, {16'd0, sd});
  endtask

  task automatic random_traffic(input int count);
    road_row_t row;
    int r;
    repeat (count) begin
      r = int'($urandom_range(0, 99));
      row.kind  = (r < 45) ? K_WRITE : (r < 78) ? K_READ :
                  (r < 95) ? K_STEP : K_UNUSED;
      row.lane  = 2'($urandom_range(0, 3));
      row.pos   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 31)) :
                                                8'($urandom_range(0, 255));
      row.wocc  = ($urandom_range(0, 9) < 7);
      row.wvel  = 4'($urandom_range(0, 15));
      row.typed = 1'b0;
      row.res   = '0;
      send_item(row);
    end
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none near the end.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= 400;
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (rx_burst != 0) begin
      rx_burst <= rx_burst - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_burst <= int'($urandom_range(0, 17));
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cell_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result item %h", out_tdata);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        if (out_tdata[0] !== want.occ) begin
          $error("cell_occupied expected %0d got %0d", want.occ, out_tdata[0]);
          errors++;
        end
        if (out_tdata[4:1] !== want.vel) begin
          $error("cell_velocity expected %0d got %0d", want.vel, out_tdata[4:1]);
          errors++;
        end
        if (out_tdata[36:5] !== want.step) begin
          $error("step_count expected %0d got %0d", want.step, out_tdata[36:5]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    road_row_t rows [$];
    foreach (road_cur[k]) begin
      road_cur[k] = '0;
      road_nxt[k] = '0;
    end
    tick = 32'd1; lfsr = mltca_pkg::SEED_DEFAULT;
    vmax = 4'd5; margin = 4'd1; inj_period = '0; slow_thr = '0; lane_thr = '0;

    rows = '{
      '{K_READ,   2'd0, 8'd0,   1'b0, 4'd0,  1'b1, {1'b0, 4'd0,  32'd1}},
      '{K_READ,   2'd3, 8'd255, 1'b0, 4'd0,  1'b1, {1'b0, 4'd0,  32'd1}},
      '{K_WRITE,  2'd3, 8'd255, 1'b1, 4'd15, 1'b1, {1'b0, 4'd0,  32'd1}},
      '{K_READ,   2'd3, 8'd255, 1'b0, 4'd0,  1'b1, {1'b1, 4'd15, 32'd1}},
      '{K_WRITE,  2'd0, 8'd0,   1'b1, 4'd0,  1'b1, {1'b0, 4'd0,  32'd1}},
      '{K_WRITE,  2'd0, 8'd3,   1'b1, 4'd15, 1'b1, {1'b0, 4'd0,  32'd1}},
      '{K_WRITE,  2'd1, 8'd10,  1'b0, 4'd10, 1'b1, {1'b0, 4'd0,  32'd1}},
      '{K_READ,   2'd1, 8'd10,  1'b0, 4'd0,  1'b1, {1'b0, 4'd10, 32'd1}},
      '{K_UNUSED, 2'd2, 8'd128, 1'b1, 4'd7,  1'b1, {1'b0, 4'd0,  32'd1}},
      '{K_WRITE,  2'd0, 8'd254, 1'b1, 4'd5,  1'b1, {1'b0, 4'd0,  32'd1}},
      '{K_WRITE,  2'd2, 8'd0,   1'b1, 4'd15, 1'b1, {1'b0, 4'd0,  32'd1}},
      '{K_WRITE,  2'd2, 8'd1,   1'b1, 4'd15, 1'b1, {1'b0, 4'd0,  32'd1}},
      '{K_STEP,   2'd0, 8'd0,   1'b0, 4'd0,  1'b0, '0},
      '{K_READ,   2'd0, 8'd1,   1'b0, 4'd0,  1'b0, '0},
      '{K_READ,   2'd0, 8'd4,   1'b0, 4'd0,  1'b0, '0},
      '{K_STEP,   2'd0, 8'd0,   1'b0, 4'd0,  1'b0, '0},
      '{K_READ,   2'd2, 8'd2,   1'b0, 4'd0,  1'b0, '0},
      '{K_WRITE,  2'd0, 8'd128, 1'b1, 4'd9,  1'b0, '0},
      '{K_STEP,   2'd0, 8'd0,   1'b0, 4'd0,  1'b0, '0},
      '{K_READ,   2'd0, 8'd128, 1'b0, 4'd0,  1'b0, '0},
      '{K_READ,   2'd3, 8'd255, 1'b0, 4'd0,  1'b0, '0},
      '{K_STEP,   2'd0, 8'd0,   1'b0, 4'd0,  1'b0, '0},
      '{K_UNUSED, 2'd1, 8'd77,  1'b0, 4'd3,  1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_item(rows[i]);

    // Fast cars, no margin, injection every step, zero seed; the receiver holds off once.
    set_road_rules(4'd15, 4'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    hold_req = 1'b1;
    random_traffic(110);

    set_road_rules(4'd1, 4'd15, 16'd65535, 16'd65535, 16'd1, 16'd65535);
    random_traffic(110);

    set_road_rules(4'd5, 4'd1, 16'd3, 16'd30000, 16'd40000, 16'd1234);
    random_traffic(110);

    set_road_rules(4'd8, 4'd2, 16'd2, 16'd1, 16'd65535, 16'd1);
    random_traffic(110);

    set_road_rules(4'($urandom_range(1, 15)), 4'($urandom_range(0, 15)),
                   16'($urandom_range(0, 4)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)));
    random_traffic(60);
    quiet = 1'b1;
    random_traffic(60);
    in_tvalid <= 1'b0;

    while (expected_cells.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_cells.size() != 0) begin
      $error("%0d expected results never arrived", expected_cells.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
